// ===== src/u2l_pkg.sv =====
package u2l_pkg;

    localparam int COUNT_BITS = 20;
    localparam int CAP_W      = 20;
    localparam int ACC_W      = 21;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]            QMARK      = 8'h3F;
    localparam logic [CAP_W-1:0]      CAP_RESET  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP  = '1;

    // register index taken from paddr[2]
    localparam logic REG_DEST_CAPACITY = 1'b0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]            out_char;
        logic                  has_char;
        logic                  fits;
        logic                  end_of_stream;
        logic [COUNT_BITS-1:0] char_count;
    } t_out_item;

endpackage

// ===== src/u2l_in_if.sv =====
interface u2l_in_if;
    logic               valid;
    logic               ready;
    u2l_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/u2l_out_if.sv =====
interface u2l_out_if;
    logic               valid;
    logic               ready;
    u2l_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/utf8_to_latin1_transcoder_core.sv =====
// Path: an accepted byte waits in the input register, then its results go to the
//   result queue, which shows its head at once; a full queue holds the byte back.
// Throughput: one byte per cycle while the queue has room for two results; the output
//   moves one result per cycle, so a byte that yields two results leaves in two transfers.
// Reset: i_rst_n is synchronous, active low; it empties the input register and
//   result queue, clears decoder state and the count, and sets capacity to 1048575.
module utf8_to_latin1_transcoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    u2l_in_if.sink                            i_src,
    u2l_out_if.source                         o_dst,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [u2l_pkg::APB_AW-1:0]        paddr,
    input  logic [u2l_pkg::APB_DW-1:0]        pwdata,
    output logic [u2l_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    // ---------------- configuration ----------------
    logic [u2l_pkg::CAP_W-1:0] r_cap;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= u2l_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == u2l_pkg::REG_DEST_CAPACITY) begin
            r_cap <= pwdata[u2l_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == u2l_pkg::REG_DEST_CAPACITY) begin
            prdata[u2l_pkg::CAP_W-1:0] = r_cap;
        end
    end

    // ---------------- input register ----------------
    logic              r_in_v;
    u2l_pkg::t_in_item r_in;
    logic [u2l_pkg::FIFO_CW-1:0] r_cnt;
    logic              adv;

    // room for two results before the stage fires
    assign adv         = r_in_v && (r_cnt <= u2l_pkg::FIFO_CW'(u2l_pkg::FIFO_DEPTH - 2));
    assign i_src.ready = !r_in_v || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_src.ready) begin
            r_in_v <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.ready && i_src.valid) begin
            r_in <= i_src.data;
        end
    end

    // ---------------- decoder ----------------
    logic [1:0]                    r_rem, n_rem;
    logic                          r_skip, n_skip;
    logic [u2l_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [u2l_pkg::COUNT_BITS-1:0] r_wc, n_wc;

    logic [7:0] b;
    logic       trail;
    logic       va, vb, vc;
    logic [7:0] chb;
    logic [u2l_pkg::ACC_W-1:0] acc_sh;
    logic [1:0] rem_dec;
    logic       k0_v, k1_v, marker;
    logic [7:0] k0_ch, k1_ch;
    logic       sat0, sat1, fits0, fits1;
    logic [u2l_pkg::COUNT_BITS-1:0] wc1, wc2;
    u2l_pkg::t_out_item res0, res1;
    logic [1:0] push_n;

    always_comb begin
        b       = r_in.in_byte;
        trail   = (b[7:6] == 2'b10);
        va      = 1'b0;
        vb      = 1'b0;
        vc      = 1'b0;
        chb     = u2l_pkg::QMARK;
        n_rem   = r_rem;
        n_skip  = r_skip;
        n_acc   = r_acc;
        acc_sh  = {r_acc[u2l_pkg::ACC_W-7:0], b[5:0]};
        rem_dec = r_rem - 2'd1;

        if (r_skip && trail) begin
            // swallowed after an invalid lead
        end else if (r_rem != 2'd0 && trail) begin
            n_skip = 1'b0;
            n_rem  = rem_dec;
            n_acc  = acc_sh;
            if (rem_dec == 2'd0) begin
                vb    = 1'b1;
                chb   = (acc_sh[u2l_pkg::ACC_W-1:8] == '0) ? acc_sh[7:0] : u2l_pkg::QMARK;
                n_acc = '0;
            end
        end else begin
            n_skip = 1'b0;
            if (r_rem != 2'd0) begin
                va    = 1'b1;          // sequence broken by a non-trailing byte
                n_rem = 2'd0;
                n_acc = '0;
            end
            if (!b[7]) begin
                vb  = 1'b1;
                chb = b;
            end else if (b[7:5] == 3'b110) begin
                n_acc = u2l_pkg::ACC_W'(b[4:0]);
                n_rem = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_acc = u2l_pkg::ACC_W'(b[3:0]);
                n_rem = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_acc = u2l_pkg::ACC_W'(b[2:0]);
                n_rem = 2'd3;
            end else begin
                vb     = 1'b1;
                chb    = u2l_pkg::QMARK;
                n_skip = 1'b1;
            end
        end

        // sequence cut off at end of buffer
        vc = r_in.last_byte && (n_rem != 2'd0);

        // pack up to two characters in order
        k0_v  = va | vb | vc;
        k0_ch = va ? u2l_pkg::QMARK : (vb ? chb : u2l_pkg::QMARK);
        k1_v  = (va & (vb | vc)) | (vb & vc);
        k1_ch = (va && vb) ? chb : u2l_pkg::QMARK;

        sat0  = (r_wc == u2l_pkg::COUNT_TOP);
        fits0 = !sat0 && (r_wc < r_cap);
        wc1   = sat0 ? r_wc : r_wc + 1'b1;
        sat1  = (wc1 == u2l_pkg::COUNT_TOP);
        fits1 = !sat1 && (wc1 < r_cap);
        wc2   = sat1 ? wc1 : wc1 + 1'b1;

        marker = r_in.last_byte && !k0_v;

        res0.out_char      = marker ? 8'h00 : k0_ch;
        res0.has_char      = !marker;
        res0.fits          = marker ? 1'b0 : fits0;
        res0.end_of_stream = r_in.last_byte && !k1_v;
        res0.char_count    = marker ? r_wc : wc1;

        res1.out_char      = k1_ch;
        res1.has_char      = 1'b1;
        res1.fits          = fits1;
        res1.end_of_stream = r_in.last_byte;
        res1.char_count    = wc2;

        if (k1_v) begin
            push_n = 2'd2;
        end else if (k0_v || marker) begin
            push_n = 2'd1;
        end else begin
            push_n = 2'd0;
        end

        n_wc = k1_v ? wc2 : (k0_v ? wc1 : r_wc);
        if (r_in.last_byte) begin
            n_rem  = 2'd0;
            n_skip = 1'b0;
            n_acc  = '0;
            n_wc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 2'd0;
            r_skip <= 1'b0;
            r_acc  <= '0;
            r_wc   <= '0;
        end else if (adv) begin
            r_rem  <= n_rem;
            r_skip <= n_skip;
            r_acc  <= n_acc;
            r_wc   <= n_wc;
        end
    end

    // ---------------- result queue ----------------
    u2l_pkg::t_out_item r_q [u2l_pkg::FIFO_DEPTH];
    logic [u2l_pkg::FIFO_PW-1:0] r_wr, r_rd;
    logic [u2l_pkg::FIFO_PW-1:0] wr1;
    logic [1:0] push;
    logic       pop;

    assign wr1  = r_wr + 1'b1;
    assign push = adv ? push_n : 2'd0;
    assign pop  = o_dst.valid && o_dst.ready;

    assign o_dst.valid = (r_cnt != '0);
    assign o_dst.data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (push == 2'd2) begin
            r_q[wr1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + u2l_pkg::FIFO_PW'(push);
            r_rd  <= r_rd + u2l_pkg::FIFO_PW'(pop);
            r_cnt <= r_cnt + u2l_pkg::FIFO_CW'(push) - u2l_pkg::FIFO_CW'(pop);
        end
    end

    // ---------------- checks ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= u2l_pkg::FIFO_CW'(u2l_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_skip_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_rem == 2'd0)
        else $error("skipping while a sequence is open");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last_byte) |=> (r_wc == '0 && r_rem == 2'd0 && !r_skip))
        else $error("state not cleared after last byte");

    a_char_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dst.valid && o_dst.data.has_char) |-> o_dst.data.char_count != '0)
        else $error("emitted character with zero count");

endmodule
